@@ hw/rtl/ccv_pkg.sv @@
// ----------------------------------------------------------------------------
// ccv_pkg
// Shared types, Q16 coefficients and channel helper functions for the
// RGB / YUV / Gray-coded color converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccv_pkg;

    typedef enum logic [2:0] {
        MODE_RGB2YUV  = 3'd0,
        MODE_YUV2RGB  = 3'd1,
        MODE_RGB2GRAY = 3'd2,
        MODE_GRAY2RGB = 3'd3,
        MODE_YUV2GRAY = 3'd4,
        MODE_GRAY2YUV = 3'd5
    } ccv_mode_t;

    typedef logic [7:0] ccv_byte_t;

    typedef struct packed {
        ccv_byte_t first;
        ccv_byte_t second;
        ccv_byte_t third;
        ccv_byte_t alpha;
    } ccv_pix_t;

    // Signed Q16 working value; wide enough for every sum in the converter.
    typedef logic signed [26:0] ccv_q16_t;
    typedef logic signed [8:0]  ccv_diff_t;
    typedef logic [16:0]        ccv_coef_t;

    // Per-stage advance enables of the pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } ccv_adv_t;

    localparam ccv_coef_t COEF_KR = 17'd19595;
    localparam ccv_coef_t COEF_KG = 17'd38470;
    localparam ccv_coef_t COEF_KB = 17'd7471;
    localparam ccv_coef_t COEF_KU = 17'd36962;
    localparam ccv_coef_t COEF_KV = 17'd46727;
    localparam ccv_coef_t COEF_RV = 17'd91947;
    localparam ccv_coef_t COEF_GV = 17'd46793;
    localparam ccv_coef_t COEF_GU = 17'd22544;
    localparam ccv_coef_t COEF_BU = 17'd116195;

    localparam ccv_q16_t Q16_HALF = 27'sd32768;
    localparam ccv_q16_t Q16_MID  = 27'sd8388608;
    localparam ccv_q16_t Q16_TOP  = 27'sd16711680;

    localparam ccv_diff_t CHROMA_OFS = 9'sd128;

    function automatic ccv_byte_t gray_enc(ccv_byte_t b);
        return b ^ (b >> 1);
    endfunction

    function automatic ccv_byte_t gray_dec(ccv_byte_t g);
        ccv_byte_t b;
        b = g;
        b = b ^ (b >> 1);
        b = b ^ (b >> 2);
        b = b ^ (b >> 4);
        return b;
    endfunction

    function automatic ccv_pix_t gray_enc_pix(ccv_pix_t p);
        ccv_pix_t r;
        r.first  = gray_enc(p.first);
        r.second = gray_enc(p.second);
        r.third  = gray_enc(p.third);
        r.alpha  = gray_enc(p.alpha);
        return r;
    endfunction

    function automatic ccv_pix_t gray_dec_pix(ccv_pix_t p);
        ccv_pix_t r;
        r.first  = gray_dec(p.first);
        r.second = gray_dec(p.second);
        r.third  = gray_dec(p.third);
        r.alpha  = gray_dec(p.alpha);
        return r;
    endfunction

    // Unsigned coefficient times a small signed value. Every product of the
    // converter fits the Q16 working width, so the low bits are exact.
    function automatic ccv_q16_t coef_mul(ccv_coef_t k, ccv_diff_t x);
        ccv_q16_t a;
        ccv_q16_t b;
        a = {10'd0, k};
        b = {{18{x[8]}}, x};
        return a * b;
    endfunction

    // Clamp to 0..255 and round half up.
    function automatic ccv_byte_t sat_q16(ccv_q16_t v);
        ccv_q16_t rnd;
        rnd = v + Q16_HALF;
        if (v < 0)
            return 8'd0;
        else if (v > Q16_TOP)
            return 8'd255;
        else
            return rnd[23:16];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ccv_pix_in_if.sv @@
// ----------------------------------------------------------------------------
// ccv_pix_in_if
// Valid/ready channel carrying one input pixel word and its mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ccv_pix_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] in_first;
    logic [7:0] in_second;
    logic [7:0] in_third;
    logic [7:0] in_alpha;

    modport source (
        output valid, mode, in_first, in_second, in_third, in_alpha,
        input  ready
    );

    modport sink (
        input  valid, mode, in_first, in_second, in_third, in_alpha,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/ccv_pix_out_if.sv @@
// ----------------------------------------------------------------------------
// ccv_pix_out_if
// Valid/ready channel carrying one converted pixel word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ccv_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_first, out_second, out_third, out_alpha,
        input  ready
    );

    modport sink (
        input  valid, out_first, out_second, out_third, out_alpha,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/ccv_in_stage.sv @@
// ----------------------------------------------------------------------------
// ccv_in_stage
// Stage 1: registers the incoming pixel, Gray-decoding it in the modes that
// take the packed Gray-coded form.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccv_in_stage (
    input  wire               clk,
    input  wire               adv,
    input  ccv_pkg::ccv_mode_t mode,
    input  ccv_pkg::ccv_pix_t pix,
    output ccv_pkg::ccv_mode_t mode_q,
    output ccv_pkg::ccv_pix_t pix_q
);
    import ccv_pkg::*;

    ccv_mode_t mode_reg;
    ccv_pix_t  pix_reg;
    ccv_pix_t  pix_next;

    always_comb
    begin
        if (mode == MODE_GRAY2RGB || mode == MODE_GRAY2YUV)
            pix_next = gray_dec_pix(pix);
        else
            pix_next = pix;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg <= mode;
            pix_reg  <= pix_next;
        end
    end

    assign mode_q = mode_reg;
    assign pix_q  = pix_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ccv_conv_stage.sv @@
// ----------------------------------------------------------------------------
// ccv_conv_stage
// Stages 2 and 3: coefficient products, then luma and RGB sums with
// clamping and rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccv_conv_stage (
    input  wire                clk,
    input  wire                adv_mul,
    input  wire                adv_sum,
    input  ccv_pkg::ccv_mode_t mode,
    input  ccv_pkg::ccv_pix_t  pix,
    output ccv_pkg::ccv_mode_t mode_q,
    output ccv_pkg::ccv_pix_t  pix_q,
    output ccv_pkg::ccv_byte_t luma_q,
    output ccv_pkg::ccv_pix_t  rgb_q
);
    import ccv_pkg::*;

    // Stage 2 registers.
    ccv_mode_t mode2_reg;
    ccv_pix_t  pix2_reg;
    ccv_q16_t  pr_kr_reg;
    ccv_q16_t  pr_kg_reg;
    ccv_q16_t  pr_kb_reg;
    ccv_q16_t  pr_rv_reg;
    ccv_q16_t  pr_gv_reg;
    ccv_q16_t  pr_gu_reg;
    ccv_q16_t  pr_bu_reg;

    // Stage 3 registers.
    ccv_mode_t mode3_reg;
    ccv_pix_t  pix3_reg;
    ccv_byte_t luma3_reg;
    ccv_pix_t  rgb3_reg;

    ccv_diff_t u_ofs;
    ccv_diff_t v_ofs;
    ccv_q16_t  y_sum;
    ccv_q16_t  y_sh;
    ccv_byte_t luma_next;
    ccv_pix_t  rgb_next;

    assign u_ofs = $signed({1'b0, pix.second}) - CHROMA_OFS;
    assign v_ofs = $signed({1'b0, pix.third}) - CHROMA_OFS;

    always_ff @(posedge clk)
    begin
        if (adv_mul)
        begin
            mode2_reg <= mode;
            pix2_reg  <= pix;
            pr_kr_reg <= coef_mul(COEF_KR, $signed({1'b0, pix.first}));
            pr_kg_reg <= coef_mul(COEF_KG, $signed({1'b0, pix.second}));
            pr_kb_reg <= coef_mul(COEF_KB, $signed({1'b0, pix.third}));
            pr_rv_reg <= coef_mul(COEF_RV, v_ofs);
            pr_gv_reg <= coef_mul(COEF_GV, v_ofs);
            pr_gu_reg <= coef_mul(COEF_GU, u_ofs);
            pr_bu_reg <= coef_mul(COEF_BU, u_ofs);
        end
    end

    // The input Y of the YUV to RGB path sits in the first channel.
    assign y_sum = pr_kr_reg + pr_kg_reg + pr_kb_reg;
    assign y_sh  = $signed({3'd0, pix2_reg.first, 16'd0});

    always_comb
    begin
        luma_next       = sat_q16(y_sum);
        rgb_next.first  = sat_q16(y_sh + pr_rv_reg);
        rgb_next.second = sat_q16(y_sh - pr_gv_reg - pr_gu_reg);
        rgb_next.third  = sat_q16(y_sh + pr_bu_reg);
        rgb_next.alpha  = pix2_reg.alpha;
    end

    always_ff @(posedge clk)
    begin
        if (adv_sum)
        begin
            mode3_reg <= mode2_reg;
            pix3_reg  <= pix2_reg;
            luma3_reg <= luma_next;
            rgb3_reg  <= rgb_next;
        end
    end

    assign mode_q = mode3_reg;
    assign pix_q  = pix3_reg;
    assign luma_q = luma3_reg;
    assign rgb_q  = rgb3_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ccv_chroma_stage.sv @@
// ----------------------------------------------------------------------------
// ccv_chroma_stage
// Stages 4 and 5: chroma products from the clamped luma, chroma clamping,
// result selection by mode and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccv_chroma_stage (
    input  wire                clk,
    input  wire                adv_mul,
    input  wire                adv_out,
    input  ccv_pkg::ccv_mode_t mode,
    input  ccv_pkg::ccv_pix_t  pix,
    input  ccv_pkg::ccv_byte_t luma,
    input  ccv_pkg::ccv_pix_t  rgb,
    output ccv_pkg::ccv_pix_t  res_q
);
    import ccv_pkg::*;

    ccv_mode_t mode4_reg;
    ccv_pix_t  pix4_reg;
    ccv_byte_t luma4_reg;
    ccv_pix_t  rgb4_reg;
    ccv_q16_t  pr_u_reg;
    ccv_q16_t  pr_v_reg;
    ccv_pix_t  res_reg;

    ccv_diff_t b_my;
    ccv_diff_t r_my;
    ccv_pix_t  yuv;
    ccv_pix_t  res_next;

    assign b_my = $signed({1'b0, pix.third}) - $signed({1'b0, luma});
    assign r_my = $signed({1'b0, pix.first}) - $signed({1'b0, luma});

    always_ff @(posedge clk)
    begin
        if (adv_mul)
        begin
            mode4_reg <= mode;
            pix4_reg  <= pix;
            luma4_reg <= luma;
            rgb4_reg  <= rgb;
            pr_u_reg  <= coef_mul(COEF_KU, b_my);
            pr_v_reg  <= coef_mul(COEF_KV, r_my);
        end
    end

    always_comb
    begin
        yuv.first  = luma4_reg;
        yuv.second = sat_q16(pr_u_reg + Q16_MID);
        yuv.third  = sat_q16(pr_v_reg + Q16_MID);
        yuv.alpha  = pix4_reg.alpha;

        case (mode4_reg)
            MODE_RGB2YUV:  res_next = yuv;
            MODE_RGB2GRAY: res_next = gray_enc_pix(yuv);
            MODE_YUV2RGB,
            MODE_GRAY2RGB: res_next = rgb4_reg;
            MODE_YUV2GRAY: res_next = gray_enc_pix(pix4_reg);
            MODE_GRAY2YUV: res_next = pix4_reg;
            default:       res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
            res_reg <= res_next;
    end

    assign res_q = res_reg;

endmodule

`default_nettype wire

@@ hw/rtl/rgb_yuv_gray_color_converter_core.sv @@
// ----------------------------------------------------------------------------
// rgb_yuv_gray_color_converter_core
// Five-stage pipelined RGBA / YUVA / Gray-coded pixel converter.
// ----------------------------------------------------------------------------
// The converter takes one pixel word per clock while nothing stalls the pipeline
// and returns the converted words in order. The pipeline stages are: input
// register with Gray decode, coefficient multipliers, luma and RGB sums with
// clamping, chroma multipliers on the clamped luma, and the chroma clamp with
// the output register. Every stage has its own valid bit and moves forward
// whenever the next stage is empty or moving, so a stall on the output fills
// the empty stages before the input is held, and bubbles are squeezed out.
// Modes 6 and 7 give an all-zero word.
`timescale 1ns / 1ps
`default_nettype none

module rgb_yuv_gray_color_converter_core (
    input  wire           clk,
    input  wire           rst_n,
    ccv_pix_in_if.sink    pix_in,
    ccv_pix_out_if.source pix_out
);
    import ccv_pkg::*;

    localparam int unsigned NUM_STAGES = 5;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    ccv_adv_t              adv;

    ccv_pix_t  in_pix;
    ccv_mode_t mode1;
    ccv_pix_t  pix1;
    ccv_mode_t mode3;
    ccv_pix_t  pix3;
    ccv_byte_t luma3;
    ccv_pix_t  rgb3;
    ccv_pix_t  res5;

    always_comb
    begin
        adv.s5 = !valid_reg[4] || pix_out.ready;
        adv.s4 = !valid_reg[3] || adv.s5;
        adv.s3 = !valid_reg[2] || adv.s4;
        adv.s2 = !valid_reg[1] || adv.s3;
        adv.s1 = !valid_reg[0] || adv.s2;
    end

    always_comb
    begin
        valid_next    = valid_reg;
        if (adv.s1)
            valid_next[0] = pix_in.valid;
        if (adv.s2)
            valid_next[1] = valid_reg[0];
        if (adv.s3)
            valid_next[2] = valid_reg[1];
        if (adv.s4)
            valid_next[3] = valid_reg[2];
        if (adv.s5)
            valid_next[4] = valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_pix.first  = pix_in.in_first;
    assign in_pix.second = pix_in.in_second;
    assign in_pix.third  = pix_in.in_third;
    assign in_pix.alpha  = pix_in.in_alpha;

    ccv_in_stage u_in_stage (
        .clk    (clk),
        .adv    (adv.s1),
        .mode   (ccv_mode_t'(pix_in.mode)),
        .pix    (in_pix),
        .mode_q (mode1),
        .pix_q  (pix1)
    );

    ccv_conv_stage u_conv_stage (
        .clk     (clk),
        .adv_mul (adv.s2),
        .adv_sum (adv.s3),
        .mode    (mode1),
        .pix     (pix1),
        .mode_q  (mode3),
        .pix_q   (pix3),
        .luma_q  (luma3),
        .rgb_q   (rgb3)
    );

    ccv_chroma_stage u_chroma_stage (
        .clk     (clk),
        .adv_mul (adv.s4),
        .adv_out (adv.s5),
        .mode    (mode3),
        .pix     (pix3),
        .luma    (luma3),
        .rgb     (rgb3),
        .res_q   (res5)
    );

    assign pix_in.ready       = adv.s1;
    assign pix_out.valid      = valid_reg[4];
    assign pix_out.out_first  = res5.first;
    assign pix_out.out_second = res5.second;
    assign pix_out.out_third  = res5.third;
    assign pix_out.out_alpha  = res5.alpha;

endmodule

`default_nettype wire

@@ hw/rtl/ccv_checker.sv @@
// ----------------------------------------------------------------------------
// ccv_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccv_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] out_first,
    input wire [7:0] out_second,
    input wire [7:0] out_third,
    input wire [7:0] out_alpha
);

    // A result word that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // A stalled result word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_first) && $stable(out_second)
            && $stable(out_third) && $stable(out_alpha))
        else $error("output word changed while stalled");

    // With the output register empty, the pipeline has room for a word.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input held back while output is empty");

    // With the output taken in every cycle in between, an accepted word comes out.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready
            ##1 out_ready |=> out_valid)
        else $error("word did not arrive after the pipeline latency");

endmodule

bind rgb_yuv_gray_color_converter_core ccv_checker u_ccv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pix_in.valid),
    .in_ready   (pix_in.ready),
    .out_valid  (pix_out.valid),
    .out_ready  (pix_out.ready),
    .out_first  (pix_out.out_first),
    .out_second (pix_out.out_second),
    .out_third  (pix_out.out_third),
    .out_alpha  (pix_out.out_alpha)
);

`default_nettype wire
